@@ rtl/fwt_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and width helpers for the fenwick tree prefix-sum core
package fwt_pkg;

    localparam int LEAF_W         = 11;
    localparam int DATA_W         = 32;
    localparam int DEF_MAX_LEAVES = 1024;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [LEAF_W-1:0] LEAF_RESET = LEAF_W'(1024);

    // input actions
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_SUM    = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    // classified commands for the back end
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SUM    = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_EMPTY  = 2'd3;

    typedef struct packed {
        logic [1:0]               action;
        logic [LEAF_W-1:0]        leaf_index;
        logic signed [DATA_W-1:0] operand_value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] prefix_total;
        logic [LEAF_W-1:0]        found_position;
    } t_out_word;

    typedef struct packed {
        logic [1:0]        op;
        logic [LEAF_W-1:0] index;
        logic [DATA_W-1:0] operand;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // width of a tree walk index: holds any node number plus one carry step
    function automatic int walk_width(input int max_leaves);
        int aw;
        aw = $clog2(max_leaves + 1);
        return ((aw > LEAF_W) ? aw : LEAF_W) + 1;
    endfunction

endpackage

@@ rtl/fwt_ram.sv @@
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module fwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/fwt_front.sv @@
`timescale 1ns / 1ps
// front end: input handshake, range checks and classification into commands
module fwt_front import fwt_pkg::*; #(
    parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  t_in_word                            i_in_word,
    input  logic [walk_width(MAX_LEAVES)-1:0]   i_n,
    input  logic                                i_clearing,
    input  t_q_status                           i_q_status,
    output logic                                o_push,
    output t_cmd                                o_cmd
);

    localparam int WW = walk_width(MAX_LEAVES);

    logic [WW-1:0] idx_ext;
    logic [WW-1:0] idx_sat;
    logic          keep;

    always_comb begin
        idx_ext = WW'(i_in_word.leaf_index);
        idx_sat = (idx_ext > i_n) ? i_n : idx_ext;
        keep        = 1'b0;
        o_cmd.op      = OP_EMPTY;
        o_cmd.index   = i_in_word.leaf_index;
        o_cmd.operand = i_in_word.operand_value;
        unique case (i_in_word.action)
            ACT_ADD: begin
                // adds outside 1..n are dropped
                keep     = (idx_ext != '0) && (idx_ext <= i_n);
                o_cmd.op = OP_ADD;
            end
            ACT_SUM: begin
                keep        = 1'b1;
                o_cmd.index = LEAF_W'(idx_sat);
                o_cmd.op    = (idx_sat == '0) ? OP_EMPTY : OP_SUM;
            end
            ACT_SEARCH: begin
                keep     = 1'b1;
                o_cmd.op = ($signed(i_in_word.operand_value) > 32'sd0) ? OP_SEARCH
                                                                       : OP_EMPTY;
            end
            ACT_NONE: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_stall = i_q_status.full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall && keep;

endmodule

@@ rtl/fwt_queue.sv @@
`timescale 1ns / 1ps
// short command queue between front and back end
module fwt_queue import fwt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    assign o_cmd          = r_mem[r_rp];
    assign o_status.full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

@@ rtl/fwt_back.sv @@
`timescale 1ns / 1ps
// back end: tree node memory, walk sequencer and result register
module fwt_back import fwt_pkg::*; #(
    parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [walk_width(MAX_LEAVES)-1:0] i_n,
    input  t_q_status                         i_q_status,
    input  t_cmd                              i_cmd,
    output logic                              o_pop,
    output logic                              o_clearing,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output t_out_word                         o_out_word
);

    localparam int WW    = walk_width(MAX_LEAVES);
    localparam int DEPTH = MAX_LEAVES + 1;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ADD    = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_SEARCH = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic              r_pending, n_pending;
    logic [WW-1:0]     r_addr, n_addr;
    logic [AW-1:0]     r_wr_addr, n_wr_addr;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_operand, n_operand;
    logic [WW-1:0]     r_pos, n_pos;
    logic [WW-1:0]     r_span, n_span;
    t_out_word         r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_out_word         r_out_word, n_out_word;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [WW-1:0] low_bit;
    logic [WW-1:0] top_span;
    logic [WW-1:0] probe;
    logic [WW-1:0] span_half;
    logic [WW-1:0] pos_next;
    logic          in_range;
    logic          take;
    logic          out_free;

    fwt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // smallest power of two above n
    always_comb begin
        top_span = '0;
        for (int b = 0; b < WW - 1; b++) begin
            if (i_n[b]) begin
                top_span = WW'(1) << (b + 1);
            end
        end
    end

    always_comb begin
        low_bit   = r_addr & (~r_addr + WW'(1));
        probe     = r_pos + r_span;
        span_half = r_span >> 1;
        in_range  = (r_span != '0) && (probe <= i_n);
        // data for the probe was read last cycle whenever it is in range
        take      = in_range && ($signed(ram_rdata) < $signed(r_operand));
        pos_next  = take ? probe : r_pos;
        out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_pending   = r_pending;
        n_addr      = r_addr;
        n_wr_addr   = r_wr_addr;
        n_acc       = r_acc;
        n_operand   = r_operand;
        n_pos       = r_pos;
        n_span      = r_span;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_wr_addr;
        ram_wdata   = ram_rdata + r_operand;
        ram_raddr   = AW'(r_addr);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == AW'(MAX_LEAVES)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop     = 1'b1;
                    n_addr    = WW'(i_cmd.index);
                    n_operand = i_cmd.operand;
                    n_acc     = '0;
                    n_pos     = '0;
                    n_span    = top_span;
                    n_pending = 1'b0;
                    n_res     = '0;
                    unique case (i_cmd.op)
                        OP_ADD:    n_state = ST_ADD;
                        OP_SUM:    n_state = ST_SUM;
                        OP_SEARCH: n_state = ST_SEARCH;
                        OP_EMPTY:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADD: begin
                // read-modify-write, one node a cycle up the low-bit chain
                ram_we = r_pending;
                if (r_addr <= i_n) begin
                    n_wr_addr = AW'(r_addr);
                    n_pending = 1'b1;
                    n_addr    = r_addr + low_bit;
                end else begin
                    n_pending = 1'b0;
                    if (!r_pending) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SUM: begin
                if (r_pending) begin
                    n_acc = r_acc + ram_rdata;
                end
                if (r_addr != '0) begin
                    n_pending = 1'b1;
                    n_addr    = r_addr - low_bit;
                end else begin
                    n_pending = 1'b0;
                    if (!r_pending) begin
                        n_res.prefix_total   = r_acc;
                        n_res.found_position = '0;
                        n_state              = ST_DONE;
                    end
                end
            end
            ST_SEARCH: begin
                // next probe issued from the decision on this one
                ram_raddr = AW'(pos_next + span_half);
                if (r_span == '0) begin
                    n_res.prefix_total   = '0;
                    n_res.found_position = LEAF_W'(r_pos + WW'(1));
                    n_state              = ST_DONE;
                end else begin
                    n_pos     = pos_next;
                    n_span    = span_half;
                    n_operand = take ? (r_operand - ram_rdata) : r_operand;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_wr_addr  <= n_wr_addr;
        r_acc      <= n_acc;
        r_operand  <= n_operand;
        r_pos      <= n_pos;
        r_span     <= n_span;
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/fenwick_tree_prefix_sum_core.sv @@
`timescale 1ns / 1ps
// fenwick tree prefix-sum core: top level with leaf count register
//
// input channel: i_in_valid / o_in_stall carry one word (add, prefix sum or
// lower bound search). output channel: o_out_valid / i_out_stall carry one
// result word for each sum or search; adds and unused actions give none.
// config channel: i_cfg_valid / o_cfg_ready write the leaf count, always ready.
// a word is taken into a two-deep command queue; the back end walks the node
// memory, one node per cycle on its single read port:
//   add    : read-modify-write of each node on the upward chain
//   sum    : one node read for each set bit of the index
//   search : one probe decided as the span halves from above n down to one
//   sum of 0 or search target of 0 or less : no walk, a result of zero
// after reset the node memory is zeroed, one node a cycle, with o_in_stall
// high; the leaf count resets to 1024.
// a stalled result stays in the output register; the back end finishes the
// next sum or search and waits, the queue fills, then o_in_stall rises.
module fenwick_tree_prefix_sum_core import fwt_pkg::*; #(
    parameter int MAX_LEAVES = DEF_MAX_LEAVES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [LEAF_W-1:0] i_cfg_data
);

    localparam int WW = walk_width(MAX_LEAVES);

    logic [LEAF_W-1:0] r_leaf_count;
    logic [WW-1:0]     count_ext;
    logic [WW-1:0]     active_n;
    logic              w_push;
    logic              w_pop;
    logic              w_clearing;
    t_cmd              w_push_cmd;
    t_cmd              w_head_cmd;
    t_q_status         w_q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_count <= LEAF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_leaf_count <= i_cfg_data;
        end
    end

    // zero counts as one leaf, anything above the memory saturates
    always_comb begin
        count_ext = WW'(r_leaf_count);
        if (count_ext == '0) begin
            active_n = WW'(1);
        end else if (count_ext > WW'(MAX_LEAVES)) begin
            active_n = WW'(MAX_LEAVES);
        end else begin
            active_n = count_ext;
        end
    end

    fwt_front #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_n        (active_n),
        .i_clearing (w_clearing),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    fwt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_push_cmd),
        .i_pop    (w_pop),
        .o_cmd    (w_head_cmd),
        .o_status (w_q_status)
    );

    fwt_back #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n         (active_n),
        .i_q_status  (w_q_status),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // the clearing pass always follows reset, so input is held off
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("push into full command queue");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty command queue");

endmodule
